### design/ple_pkg.sv
// Shared constants, codes and types of the positional list engine.
`default_nettype none

package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W    = $clog2(CAPACITY + 1);

	localparam int OP_W   = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 7;
	localparam int FPOS_W = 6;
	localparam int ST_W   = 2;
	localparam int LLEN_W = 7;

	// common width for position / length / counter compares
	localparam int CMP_W0 = (LEN_W > POS_W) ? LEN_W : POS_W;
	localparam int CMP_W  = (CMP_W0 > IDX_W) ? CMP_W0 : IDX_W;

	typedef enum logic [OP_W-1:0] {
		OP_READ         = 3'd0,
		OP_WRITE        = 3'd1,
		OP_INSERT       = 3'd2,
		OP_REMOVE_AT    = 3'd3,
		OP_SEARCH       = 3'd4,
		OP_REMOVE_VALUE = 3'd5,
		OP_DROP         = 3'd6,
		OP_CLEAR        = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_ROT,
		CM_WR,
		CM_INS,
		CM_DEL
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic [IDX_W-1:0]         pos;
		logic signed [VAL_W-1:0]  val;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEL,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

### design/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer plus a row of storage cells.
// Work per transaction: read, remove at, search and remove value scan one full ring rotation
// of the cell row; remove at / remove value on a hit add a delete shift; write, insert and
// clear act once; drop n rotates up to n head entries out. Results leave through a finish state.
// A new transaction is taken only once the last one has finished; a stalled result delays this.
// Reset clears control state only: length, counters, hit flag, handshake. Cells start undefined.
`default_nettype none

module positional_list_engine_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ple_pkg::OP_W-1:0]          op,
	input  wire logic [ple_pkg::POS_W-1:0]         position,
	input  wire logic signed [ple_pkg::VAL_W-1:0]  value,
	input  wire logic [ple_pkg::CNT_W-1:0]         drop_count,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [ple_pkg::VAL_W-1:0]       result_value,
	output logic [ple_pkg::FPOS_W-1:0]             found_position,
	output logic [ple_pkg::ST_W-1:0]               status,
	output logic [ple_pkg::LLEN_W-1:0]             list_length
);
	import ple_pkg::*;

	// Cell i holds list entry i. Every cell sees the same command each cycle:
	//   rotate  - all cells take from the right neighbour, last cell takes cell 0,
	//             so the head (cell 0) walks through the list in index order;
	//             CAPACITY rotations bring the row back to its original order
	//   write   - the addressed cell loads the value
	//   insert  - cells above the position take from the left, the position loads the value
	//   delete  - cells at and above the position take from the right
	// Searches and positional reads watch the head during a full rotation.
	// Dropping n entries is n rotations; what wraps round lies beyond the length.

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] cell_vals [CAPACITY];
	logic signed [VAL_W-1:0] head_val;

	assign head_val = cell_vals[0];

	ple_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.position       (position),
		.value          (value),
		.drop_count     (drop_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.found_position (found_position),
		.status         (status),
		.list_length    (list_length),
		.head_val       (head_val),
		.ctl            (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		// cell 0 never shifts in from the left; the ring closes at the far end
		if (i == 0) begin : g_first
			assign left_v = ctl.val;
		end else begin : g_mid
			assign left_v = cell_vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_vals[0];
		end else begin : g_inner
			assign right_v = cell_vals[i+1];
		end

		ple_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cell_idx  (IDX_W'(i)),
			.left_val  (left_v),
			.right_val (right_v),
			.cell_val  (cell_vals[i])
		);
	end

endmodule

`default_nettype wire

### design/ple_cell.sv
// One storage cell of the list row: holds one entry, shifts to or from its neighbours.
`default_nettype none

module ple_cell (
	input  wire logic                              clk,
	input  wire ple_pkg::cell_ctl_t                ctl,
	input  wire logic [ple_pkg::IDX_W-1:0]         cell_idx,
	input  wire logic signed [ple_pkg::VAL_W-1:0]  left_val,
	input  wire logic signed [ple_pkg::VAL_W-1:0]  right_val,
	output logic signed [ple_pkg::VAL_W-1:0]       cell_val
);
	import ple_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_ROT: val_q <= right_val;
			CM_WR: begin
				if (cell_idx == ctl.pos) val_q <= ctl.val;
			end
			CM_INS: begin
				if (cell_idx > ctl.pos) val_q <= left_val;
				else if (cell_idx == ctl.pos) val_q <= ctl.val;
			end
			CM_DEL: begin
				if (cell_idx >= ctl.pos) val_q <= right_val;
			end
			default: ;
		endcase
	end

	assign cell_val = val_q;

endmodule

`default_nettype wire

### design/ple_ctrl.sv
// Sequencer of the list engine: handshakes, length, scan counter and result register.
`default_nettype none

module ple_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ple_pkg::OP_W-1:0]          op,
	input  wire logic [ple_pkg::POS_W-1:0]         position,
	input  wire logic signed [ple_pkg::VAL_W-1:0]  value,
	input  wire logic [ple_pkg::CNT_W-1:0]         drop_count,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [ple_pkg::VAL_W-1:0]       result_value,
	output logic [ple_pkg::FPOS_W-1:0]             found_position,
	output logic [ple_pkg::ST_W-1:0]               status,
	output logic [ple_pkg::LLEN_W-1:0]             list_length,
	input  wire logic signed [ple_pkg::VAL_W-1:0]  head_val,
	output ple_pkg::cell_ctl_t                     ctl
);
	import ple_pkg::*;

	state_t state_q, state_d;

	// control
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] k_q;
	logic [LEN_W-1:0] rem_q;
	logic             hit_q;
	logic             out_valid_q;

	// transaction payload
	op_t                     op_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] cap_q;
	logic signed [VAL_W-1:0] rres_q;
	status_t                 rst_q;
	logic [FPOS_W-1:0]       rfpos_q;

	// output register
	logic signed [VAL_W-1:0] res_out_q;
	logic [FPOS_W-1:0]       fpos_out_q;
	status_t                 st_out_q;
	logic [LLEN_W-1:0]       len_out_q;

	logic                    in_acc;
	logic [CMP_W-1:0]        pos_ext, len_ext, k_ext, cnt_ext;
	logic                    pos_ok, ins_bad_pos, ins_ok;
	logic                    is_search, is_remove, is_scan;
	logic                    match_now, scan_last, found_fin, remove_go;
	logic [IDX_W-1:0]        idx_fin;
	logic signed [VAL_W-1:0] val_fin;
	logic [LEN_W-1:0]        rem_init;
	logic                    fin_go;

	assign in_acc  = in_valid && !in_stall;
	assign pos_ext = CMP_W'(pos_q);
	assign len_ext = CMP_W'(len_q);
	assign k_ext   = CMP_W'(k_q);
	assign cnt_ext = CMP_W'(drop_count);

	assign pos_ok      = pos_ext < len_ext;
	assign ins_bad_pos = pos_ext > len_ext;
	assign ins_ok      = !ins_bad_pos && (len_q < LEN_W'(CAPACITY));

	assign is_search = (op_q == OP_SEARCH) || (op_q == OP_REMOVE_VALUE);
	assign is_remove = (op_q == OP_REMOVE_AT) || (op_q == OP_REMOVE_VALUE);
	assign is_scan   = is_search || (op_q == OP_READ) || (op_q == OP_REMOVE_AT);

	// first hit for a search, positional hit otherwise
	assign match_now = is_search ? (!hit_q && (head_val == val_q) && (k_ext < len_ext))
	                             : (k_ext == pos_ext);
	assign scan_last = (k_q == IDX_W'(CAPACITY - 1));
	assign found_fin = is_search ? (hit_q || match_now) : pos_ok;
	assign remove_go = is_remove && found_fin;
	assign idx_fin   = match_now ? k_q : idx_q;
	assign val_fin   = match_now ? head_val : cap_q;

	assign rem_init = (cnt_ext > len_ext) ? len_q : LEN_W'(drop_count);
	assign fin_go   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		ctl.mode = CM_HOLD;
		ctl.pos  = idx_q;
		ctl.val  = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (op_q) inside
					OP_READ, OP_REMOVE_AT, OP_SEARCH, OP_REMOVE_VALUE: begin
						ctl.mode = CM_ROT;
						if (scan_last) state_d = remove_go ? S_DEL : S_FIN;
					end
					OP_WRITE: begin
						if (pos_ok) ctl.mode = CM_WR;
						state_d = S_FIN;
					end
					OP_INSERT: begin
						if (ins_ok) ctl.mode = CM_INS;
						state_d = S_FIN;
					end
					OP_DROP: begin
						if (rem_q == '0) state_d = S_FIN;
						else ctl.mode = CM_ROT;
					end
					OP_CLEAR: state_d = S_FIN;
					default: state_d = S_FIN;
				endcase
			end
			S_DEL: begin
				ctl.mode = CM_DEL;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			k_q         <= '0;
			rem_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == S_FIN && fin_go) out_valid_q <= 1'b1;
			if (in_acc) begin
				hit_q <= 1'b0;
				k_q   <= '0;
				rem_q <= rem_init;
			end
			if (state_q == S_EXEC) begin
				case (op_q) inside
					OP_READ, OP_REMOVE_AT, OP_SEARCH, OP_REMOVE_VALUE: begin
						k_q <= scan_last ? '0 : k_q + 1'b1;
						if (match_now) hit_q <= 1'b1;
					end
					OP_INSERT: begin
						if (ins_ok) len_q <= len_q + 1'b1;
					end
					OP_DROP: begin
						if (rem_q != '0) begin
							rem_q <= rem_q - 1'b1;
							len_q <= len_q - 1'b1;
						end
					end
					OP_CLEAR: len_q <= '0;
					default: ;
				endcase
			end
			if (state_q == S_DEL) len_q <= len_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= op_t'(op);
			pos_q   <= position;
			val_q   <= value;
			idx_q   <= IDX_W'(position);
			rres_q  <= '0;
			rst_q   <= ST_OK;
			rfpos_q <= '0;
		end
		if (state_q == S_EXEC) begin
			if (is_scan) begin
				if (match_now) begin
					cap_q <= head_val;
					idx_q <= k_q;
				end
				if (scan_last) begin
					if (found_fin) begin
						rres_q <= val_fin;
						idx_q  <= idx_fin;
						if (is_search) rfpos_q <= FPOS_W'(idx_fin);
					end else begin
						rres_q <= '1;
						rst_q  <= is_search ? ST_NOT_FOUND : ST_BAD_POS;
					end
				end
			end else if (op_q == OP_WRITE) begin
				if (!pos_ok) begin
					rres_q <= '1;
					rst_q  <= ST_BAD_POS;
				end
			end else if (op_q == OP_INSERT) begin
				if (ins_bad_pos) begin
					rres_q <= '1;
					rst_q  <= ST_BAD_POS;
				end else if (!ins_ok) begin
					rst_q <= ST_FULL;
				end
			end
		end
		if (state_q == S_FIN && fin_go) begin
			res_out_q  <= rres_q;
			fpos_out_q <= rfpos_q;
			st_out_q   <= rst_q;
			len_out_q  <= LLEN_W'(len_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = res_out_q;
	assign found_position = fpos_out_q;
	assign status         = st_out_q;
	assign list_length    = len_out_q;

	// a full report only comes from a list at capacity
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (st_out_q == ST_FULL) |-> len_out_q == LLEN_W'(CAPACITY))
		else $error("full status with list not at capacity");

	// a miss always carries all ones
	a_miss_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (st_out_q == ST_NOT_FOUND || st_out_q == ST_BAD_POS)
		|-> res_out_q == '1)
		else $error("error status without all-ones result");

	// length only moves while a transaction is being worked
	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |=> $stable(len_q))
		else $error("length changed outside execution");

	// scan always restarts from the head
	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && is_scan && scan_last |=> k_q == '0)
		else $error("scan counter not rewound");

	// never more entries than cells
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && (op_q == OP_INSERT) |=> len_q <= LEN_W'(CAPACITY))
		else $error("length beyond capacity");

endmodule

`default_nettype wire

### tb/sv/positional_list_engine_core_tb.sv
// Self-checking testbench for the positional list engine: directed, full-list and random transactions.
`timescale 1ns / 1ps

module positional_list_engine_core_tb;
	import ple_pkg::*;

	localparam int QUIET_LIMIT = 4000;	// cycles with no transaction on either channel
	localparam int RANDOM_ITEMS_PER_PHASE = 463;

	typedef struct packed {
		logic [VAL_W-1:0]  val;
		logic [FPOS_W-1:0] fpos;
		status_t           st;
		logic [LLEN_W-1:0] len;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          op = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic [CNT_W-1:0]         drop_count = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [VAL_W-1:0]  result_value;
	logic [FPOS_W-1:0]        found_position;
	logic [ST_W-1:0]          status;
	logic [LLEN_W-1:0]        list_length;

	// Shadow copy of the ordered list, kept in step with accepted requests
	logic [VAL_W-1:0] shadow_list[$];
	// Results owed by the block, oldest first
	list_result_t     owed_results[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	positional_list_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.position       (position),
		.value          (value),
		.drop_count     (drop_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.found_position (found_position),
		.status         (status),
		.list_length    (list_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one request to the shadow list and returns the result it should give.
	// Bad position is checked before full, so an out-of-range insert on a full list
	// reports a bad position.
	task automatic apply_list_op(input op_t o, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] v, input logic [CNT_W-1:0] cnt,
			output list_result_t r);
		int len;
		int hit;
		int n;
		len = shadow_list.size();
		hit = -1;
		r = '{val: '0, fpos: '0, st: ST_OK, len: '0};
		if (o == OP_SEARCH || o == OP_REMOVE_VALUE) begin
			for (int k = 0; k < len; k++) begin
				if (hit < 0 && shadow_list[k] == v)
					hit = k;
			end
		end
		case (o)
			OP_READ, OP_WRITE, OP_REMOVE_AT: begin
				if (int'(pos) < len) begin
					if (o == OP_WRITE)
						shadow_list[pos] = v;
					else
						r.val = shadow_list[pos];
					if (o == OP_REMOVE_AT)
						shadow_list.delete(pos);
				end else begin
					r.val = '1;
					r.st = ST_BAD_POS;
				end
			end
			OP_INSERT: begin
				if (int'(pos) > len) begin
					r.val = '1;
					r.st = ST_BAD_POS;
				end else if (len >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					shadow_list.insert(pos, v);
				end
			end
			OP_SEARCH, OP_REMOVE_VALUE: begin
				if (hit >= 0) begin
					r.val = shadow_list[hit];
					r.fpos = hit[FPOS_W-1:0];
					if (o == OP_REMOVE_VALUE)
						shadow_list.delete(hit);
				end else begin
					r.val = '1;
					r.st = ST_NOT_FOUND;
				end
			end
			OP_DROP: begin
				// count clamped to the current length
				n = (int'(cnt) > len) ? len : int'(cnt);
				repeat (n) shadow_list.delete(0);
			end
			default: begin
				shadow_list.delete();
			end
		endcase
		r.len = LLEN_W'(shadow_list.size());
	endtask

	// Presents one request, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send_request(input op_t o, input int unsigned pos,
			input logic [VAL_W-1:0] v, input int unsigned cnt);
		list_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			op <= OP_W'($urandom);
			position <= POS_W'($urandom);
			value <= $urandom;
			drop_count <= CNT_W'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		position <= pos[POS_W-1:0];
		value <= v;
		drop_count <= cnt[CNT_W-1:0];
		do @(posedge clk); while (in_stall);
		apply_list_op(o, pos[POS_W-1:0], v, cnt[CNT_W-1:0], r);
		owed_results.push_back(r);
	endtask

	// Lowers valid, waits for every owed result, then lets the block settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
	endtask

	// Empty list, boundary values, duplicates and first-match behaviour.
	task automatic test_directed();
		send_request(OP_READ, 0, 32'd0, 0);		// empty list: bad position
		send_request(OP_REMOVE_AT, 0, 32'd0, 0);
		send_request(OP_WRITE, 0, 32'd9, 0);
		send_request(OP_SEARCH, 0, 32'd5, 0);	// not found
		send_request(OP_REMOVE_VALUE, 0, 32'd5, 0);
		send_request(OP_DROP, 0, 32'd0, 3);
		send_request(OP_INSERT, 1, 32'd1, 0);	// past the end
		send_request(OP_INSERT, 0, 32'h7FFF_FFFF, 0);
		send_request(OP_INSERT, 0, 32'h8000_0000, 0);
		send_request(OP_INSERT, 2, 32'hFFFF_FFFF, 0);
		send_request(OP_INSERT, 1, 32'd5, 0);
		send_request(OP_INSERT, 4, 32'd5, 0);	// duplicate at the tail
		send_request(OP_READ, 0, 32'd0, 0);
		send_request(OP_READ, 4, 32'd0, 0);
		send_request(OP_READ, 5, 32'd0, 0);
		send_request(OP_WRITE, 2, 32'd0, 0);
		send_request(OP_SEARCH, 0, 32'd5, 0);	// first of two matches
		send_request(OP_REMOVE_VALUE, 0, 32'd5, 0);
		send_request(OP_SEARCH, 0, 32'd5, 0);
		send_request(OP_REMOVE_AT, 3, 32'd0, 0);
		send_request(OP_DROP, 0, 32'd0, 0);
		send_request(OP_DROP, 0, 32'd0, 64);	// clamped to length
		send_request(OP_CLEAR, 0, 32'd0, 0);
		wait_drained();
	endtask

	// Fill to capacity, then hit the full and out-of-range cases at the top end.
	task automatic test_full_list();
		for (int k = 0; k < CAPACITY; k++)
			send_request(OP_INSERT, $urandom_range(k), $urandom, 0);
		send_request(OP_INSERT, 0, 32'd1, 0);
		send_request(OP_INSERT, CAPACITY, 32'd2, 0);
		send_request(OP_INSERT, 127, 32'd3, 0);	// out of range and full
		send_request(OP_READ, CAPACITY - 1, 32'd0, 0);
		send_request(OP_READ, CAPACITY, 32'd0, 0);
		send_request(OP_READ, 127, 32'd0, 0);
		send_request(OP_SEARCH, 0, shadow_list[CAPACITY-1], 0);
		send_request(OP_WRITE, CAPACITY - 1, 32'h8000_0000, 0);
		send_request(OP_REMOVE_AT, CAPACITY - 1, 32'd0, 0);
		send_request(OP_INSERT, CAPACITY - 1, 32'h7FFF_FFFF, 0);
		send_request(OP_REMOVE_VALUE, 0, shadow_list[0], 0);
		send_request(OP_DROP, 0, 32'd0, CAPACITY);
		wait_drained();
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 30 && shadow_list.size() != 0)
			return shadow_list[$urandom_range(shadow_list.size() - 1)];
		if (r < 50)
			return $urandom_range(7);
		if (r < 60) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'd0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic int unsigned pick_position(input bit for_insert);
		int r;
		int len;
		r = $urandom_range(99);
		len = shadow_list.size();
		if (r < 8)
			return $urandom_range(CAPACITY);
		if (r < 10)
			return $urandom_range(127, CAPACITY + 1);
		if (for_insert)
			return $urandom_range(len);
		return (len == 0) ? 0 : $urandom_range(len - 1);
	endfunction

	// Random mix leaning towards insert so the length wanders up to full and back.
	task automatic test_random(input int idle_pct, input int hold_pct);
		int r;
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
			r = $urandom_range(99);
			if (r < 36)
				send_request(OP_INSERT, pick_position(1'b1), pick_value(), $urandom_range(64));
			else if (r < 50)
				send_request(OP_READ, pick_position(1'b0), pick_value(), $urandom_range(64));
			else if (r < 58)
				send_request(OP_WRITE, pick_position(1'b0), pick_value(), $urandom_range(64));
			else if (r < 68)
				send_request(OP_REMOVE_AT, pick_position(1'b0), pick_value(), $urandom_range(64));
			else if (r < 78)
				send_request(OP_SEARCH, $urandom_range(64), pick_value(), $urandom_range(64));
			else if (r < 87)
				send_request(OP_REMOVE_VALUE, $urandom_range(64), pick_value(),
					$urandom_range(64));
			else if (r < 98)
				send_request(OP_DROP, $urandom_range(64), pick_value(),
					($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(64));
			else
				send_request(OP_CLEAR, $urandom_range(64), pick_value(), $urandom_range(64));
		end
		wait_drained();
	endtask

	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic report_mismatch(input string field, input longint want, input longint got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// Result checker: each accepted result against the oldest owed one
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (owed_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual value %0h status %0d",
					$time, result_value, status);
			end else begin
				want = owed_results.pop_front();
				if (result_value !== want.val)
					report_mismatch("result_value", want.val, result_value);
				if (found_position !== want.fpos)
					report_mismatch("found_position", want.fpos, found_position);
				if (status !== want.st)
					report_mismatch("status", want.st, status);
				if (list_length !== want.len)
					report_mismatch("list_length", want.len, list_length);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_list();
		test_random(0, 0);
		test_random(79, 0);
		test_random(0, 79);
		test_random(30, 30);
		if (mismatch_count == 0 && owed_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### positional_list_engine_core.f
design/ple_pkg.sv
design/ple_cell.sv
design/ple_ctrl.sv
design/positional_list_engine_core.sv
tb/sv/positional_list_engine_core_tb.sv
